/* sv/arm_load_store_move_unit_core_defines.svh */
// Assertion helpers used by the back-end RTL file.
`ifndef ARM_LOAD_STORE_MOVE_UNIT_CORE_DEFINES_SVH
`define ARM_LOAD_STORE_MOVE_UNIT_CORE_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define LSMU_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("lsmu same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define LSMU_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("lsmu next-cycle check failed");

`endif

/* sv/arm_lsmu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package arm_lsmu_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int ADDR_W      = $clog2(MEM_BYTES);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] SP_INDEX = 4'd13;
    localparam logic [3:0] PC_INDEX = 4'd15;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FAULT   = 2'd2;

    // operation codes
    localparam logic [2:0] OP_MOV   = 3'd0;
    localparam logic [2:0] OP_MOVS  = 3'd1;
    localparam logic [2:0] OP_LOAD  = 3'd2;
    localparam logic [2:0] OP_STORE = 3'd3;
    localparam logic [2:0] OP_PUSH  = 3'd4;
    localparam logic [2:0] OP_POP   = 3'd5;

    // addressing modes
    localparam logic [2:0] MODE_BASE     = 3'd0;
    localparam logic [2:0] MODE_DISP     = 3'd1;
    localparam logic [2:0] MODE_INDEX    = 3'd2;
    localparam logic [2:0] MODE_PRE      = 3'd3;
    localparam logic [2:0] MODE_POST     = 3'd4;
    localparam logic [2:0] MODE_ABSOLUTE = 3'd5;

    localparam logic [1:0] WIDTH_WORD = 2'd2;

    typedef enum logic [2:0] {
        KIND_MOVE  = 3'd0,
        KIND_LOAD  = 3'd1,
        KIND_STORE = 3'd2,
        KIND_PUSH  = 3'd3,
        KIND_POP   = 3'd4,
        KIND_BAD   = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic        set_flags;
        logic        lit;
        logic [2:0]  mode;
        logic [1:0]  last_cnt;
        logic [3:0]  rd;
        logic [3:0]  rn;
        logic [3:0]  rm;
        logic [31:0] disp;
        logic [31:0] literal;
        logic [15:0] sel;
    } cmd_t;

    // True when an access of nbytes at addr stays inside memory.
    function automatic logic in_range(input logic [31:0] addr, input logic [2:0] nbytes);
        logic [32:0] last;
        last = {1'b0, addr} + {30'b0, nbytes};
        return last <= 33'(MEM_BYTES);
    endfunction

endpackage
`default_nettype wire

/* sv/arm_lsmu_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module arm_lsmu_front
    import arm_lsmu_pkg::*;
(
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [2:0]   s_tuser,
    input  wire logic [103:0] s_tdata,
    input  wire logic         q_full,
    output logic              q_push,
    output cmd_t              q_cmd
);
    logic [1:0]  width;
    logic [2:0]  mode;
    logic        use_mask;
    logic [3:0]  rd;
    logic [15:0] mask;

    // unpack the payload
    assign width    = s_tdata[1:0];
    assign mode     = s_tdata[4:2];
    assign use_mask = s_tdata[6];
    assign rd       = s_tdata[10:7];
    assign mask     = s_tdata[98:83];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // classify the transfer into a command for the back end
    always_comb begin
        q_cmd           = '0;
        q_cmd.lit       = s_tdata[5];
        q_cmd.mode      = mode;
        q_cmd.rd        = rd;
        q_cmd.rn        = s_tdata[14:11];
        q_cmd.rm        = s_tdata[18:15];
        q_cmd.disp      = s_tdata[50:19];
        q_cmd.literal   = s_tdata[82:51];
        q_cmd.sel       = use_mask ? mask : (16'd1 << rd);
        q_cmd.last_cnt  = 2'd3;
        q_cmd.set_flags = (s_tuser == OP_MOVS);
        case (s_tuser)
            OP_MOV, OP_MOVS: begin
                q_cmd.kind = KIND_MOVE;
            end
            OP_LOAD, OP_STORE: begin
                q_cmd.kind = (s_tuser == OP_LOAD) ? KIND_LOAD : KIND_STORE;
                if (width > WIDTH_WORD || mode > MODE_ABSOLUTE) begin
                    q_cmd.kind = KIND_BAD;
                end
                q_cmd.last_cnt = (width == WIDTH_WORD) ? 2'd3 : {1'b0, width[0]};
            end
            OP_PUSH: begin
                q_cmd.kind = KIND_PUSH;
            end
            OP_POP: begin
                q_cmd.kind = KIND_POP;
            end
            default: begin
                q_cmd.kind = KIND_BAD;
            end
        endcase
    end
endmodule
`default_nettype wire

/* sv/arm_lsmu_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module arm_lsmu_queue
    import arm_lsmu_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output cmd_t      pop_cmd
);
    cmd_t               slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    // store incoming commands
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

/* sv/arm_lsmu_back.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "arm_load_store_move_unit_core_defines.svh"
module arm_lsmu_back
    import arm_lsmu_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_empty,
    input  wire cmd_t        q_cmd,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata
);
    typedef enum logic [16:0] {
        S_CLEAR       = 17'h00001,
        S_IDLE        = 17'h00002,
        S_DISPATCH    = 17'h00004,
        S_MOV_RD      = 17'h00008,
        S_LS_BASE     = 17'h00010,
        S_LS_INDEX    = 17'h00020,
        S_LS_SRC      = 17'h00040,
        S_LS_ADDR     = 17'h00080,
        S_LS_CHECK    = 17'h00100,
        S_MEM_RD      = 17'h00200,
        S_MEM_WAIT    = 17'h00400,
        S_MEM_WR      = 17'h00800,
        S_COMMIT_WB   = 17'h01000,
        S_COMMIT_DEST = 17'h02000,
        S_PUSH_SCAN   = 17'h04000,
        S_PUSH_RD     = 17'h08000,
        S_POP_SCAN    = 17'h10000
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [31:0]        rn_val_reg, rn_val_next;
    logic [31:0]        idxv_reg, idxv_next;
    logic [31:0]        src_reg, src_next;
    logic [31:0]        ea_reg, ea_next;
    logic [31:0]        nb_reg, nb_next;
    logic [31:0]        acc_reg, acc_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic [3:0]         ridx_reg, ridx_next;
    logic [31:0]        wval_reg, wval_next;
    logic [31:0]        sp_reg;
    logic               flag_n_reg, flag_n_next;
    logic               flag_z_reg, flag_z_next;

    // register file: one write port, one registered read port
    logic [31:0]        rf_mem [16];
    logic [15:0]        rf_valid_reg;
    logic [31:0]        rf_raw_reg;
    logic [3:0]         rf_raddr_q_reg;
    logic [3:0]         rf_raddr;
    logic               rf_we;
    logic [3:0]         rf_waddr;
    logic [31:0]        rf_wdata;
    logic [31:0]        rf_q;

    // byte memory
    logic [7:0]         dmem [MEM_BYTES];
    logic [7:0]         mem_q_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_addr;
    logic [7:0]         mem_wdata;

    // result register
    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [31:0]        out_wval_reg;
    logic [31:0]        out_ea_reg;
    logic               out_n_reg;
    logic               out_z_reg;
    logic               fin;
    logic [1:0]         fin_status;
    logic [31:0]        fin_wval;
    logic [31:0]        fin_ea;

    logic [31:0]        mov_val;
    logic [31:0]        push_slot;
    logic               last_byte;
    logic               write_back;

    assign rf_q = (rf_raddr_q_reg == SP_INDEX) ? sp_reg :
                  (rf_valid_reg[rf_raddr_q_reg] ? rf_raw_reg : 32'd0);
    assign push_slot  = sp_reg - 32'd4;
    assign last_byte  = (cnt_reg == cmd_reg.last_cnt);
    assign write_back = (cmd_reg.mode == MODE_PRE) || (cmd_reg.mode == MODE_POST);
    assign mem_addr   = (state_reg == S_CLEAR) ? clr_cnt_reg :
                        ea_reg[ADDR_W-1:0] + {{(ADDR_W-2){1'b0}}, cnt_reg};
    assign q_pop      = (state_reg == S_IDLE) && !q_empty && !out_valid_reg;

    // sequence one command
    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        clr_cnt_next = clr_cnt_reg;
        rn_val_next  = rn_val_reg;
        idxv_next    = idxv_reg;
        src_next     = src_reg;
        ea_next      = ea_reg;
        nb_next      = nb_reg;
        acc_next     = acc_reg;
        cnt_next     = cnt_reg;
        ridx_next    = ridx_reg;
        wval_next    = wval_reg;
        flag_n_next  = flag_n_reg;
        flag_z_next  = flag_z_reg;
        rf_raddr     = cmd_reg.rm;
        rf_we        = 1'b0;
        rf_waddr     = cmd_reg.rd;
        rf_wdata     = acc_reg;
        mem_we       = 1'b0;
        mem_wdata    = src_reg[8*cnt_reg +: 8];
        fin          = 1'b0;
        fin_status   = ST_OK;
        fin_wval     = 32'd0;
        fin_ea       = 32'd0;
        mov_val      = cmd_reg.lit ? cmd_reg.literal : rf_q;
        case (state_reg)
            S_CLEAR: begin
                mem_we       = 1'b1;
                mem_wdata    = 8'd0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(MEM_BYTES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_pop) begin
                    cmd_next   = q_cmd;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                wval_next = 32'd0;
                case (cmd_reg.kind)
                    KIND_MOVE: begin
                        if (cmd_reg.lit) begin
                            rf_we    = 1'b1;
                            rf_wdata = mov_val;
                            fin      = 1'b1;
                            fin_wval = mov_val;
                            if (cmd_reg.set_flags) begin
                                flag_n_next = mov_val[31];
                                flag_z_next = (mov_val == 32'd0);
                            end
                        end else begin
                            state_next = S_MOV_RD;
                        end
                    end
                    KIND_LOAD, KIND_STORE: begin
                        rf_raddr   = cmd_reg.rn;
                        state_next = S_LS_BASE;
                    end
                    KIND_PUSH: begin
                        ridx_next  = PC_INDEX;
                        state_next = S_PUSH_SCAN;
                    end
                    KIND_POP: begin
                        ridx_next  = 4'd0;
                        state_next = S_POP_SCAN;
                    end
                    default: begin
                        fin        = 1'b1;
                        fin_status = ST_INVALID;
                    end
                endcase
            end
            S_MOV_RD: begin
                rf_we    = 1'b1;
                rf_wdata = mov_val;
                fin      = 1'b1;
                fin_wval = mov_val;
                if (cmd_reg.set_flags) begin
                    flag_n_next = mov_val[31];
                    flag_z_next = (mov_val == 32'd0);
                end
            end
            S_LS_BASE: begin
                rn_val_next = rf_q;
                rf_raddr    = cmd_reg.rm;
                state_next  = S_LS_INDEX;
            end
            S_LS_INDEX: begin
                idxv_next  = rf_q;
                rf_raddr   = cmd_reg.rd;
                state_next = S_LS_SRC;
            end
            S_LS_SRC: begin
                src_next   = rf_q;
                state_next = S_LS_ADDR;
            end
            // resolve the address and the written-back base
            S_LS_ADDR: begin
                nb_next = rn_val_reg + cmd_reg.disp;
                case (cmd_reg.mode)
                    MODE_DISP, MODE_PRE: ea_next = rn_val_reg + cmd_reg.disp;
                    MODE_INDEX:          ea_next = rn_val_reg + idxv_reg;
                    MODE_ABSOLUTE:       ea_next = cmd_reg.literal;
                    default:             ea_next = rn_val_reg;
                endcase
                state_next = S_LS_CHECK;
            end
            S_LS_CHECK: begin
                cnt_next = 2'd0;
                acc_next = 32'd0;
                if (!in_range(ea_reg, {1'b0, cmd_reg.last_cnt} + 3'd1)) begin
                    fin        = 1'b1;
                    fin_status = ST_FAULT;
                    fin_ea     = ea_reg;
                end else if (cmd_reg.kind == KIND_LOAD) begin
                    state_next = S_MEM_RD;
                end else begin
                    state_next = S_MEM_WR;
                end
            end
            S_MEM_RD: begin
                state_next = S_MEM_WAIT;
            end
            // gather one byte, little endian
            S_MEM_WAIT: begin
                acc_next[8*cnt_reg +: 8] = mem_q_reg;
                if (last_byte) begin
                    state_next = S_COMMIT_WB;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_MEM_RD;
                end
            end
            S_MEM_WR: begin
                mem_we = 1'b1;
                if (!last_byte) begin
                    cnt_next = cnt_reg + 1'b1;
                end else if (cmd_reg.kind == KIND_STORE) begin
                    state_next = S_COMMIT_WB;
                end else if (ridx_reg == 4'd0) begin
                    fin = 1'b1;
                end else begin
                    ridx_next  = ridx_reg - 1'b1;
                    state_next = S_PUSH_SCAN;
                end
            end
            S_COMMIT_WB: begin
                if (cmd_reg.kind == KIND_POP) begin
                    rf_we      = 1'b1;
                    rf_waddr   = SP_INDEX;
                    rf_wdata   = ea_reg + 32'd4;
                    state_next = S_COMMIT_DEST;
                end else begin
                    rf_we    = write_back;
                    rf_waddr = cmd_reg.rn;
                    rf_wdata = nb_reg;
                    if (cmd_reg.kind == KIND_STORE) begin
                        fin    = 1'b1;
                        fin_ea = ea_reg;
                    end else begin
                        state_next = S_COMMIT_DEST;
                    end
                end
            end
            S_COMMIT_DEST: begin
                rf_we = 1'b1;
                if (cmd_reg.kind == KIND_POP) begin
                    rf_waddr  = ridx_reg;
                    wval_next = acc_reg;
                    if (ridx_reg == PC_INDEX) begin
                        fin      = 1'b1;
                        fin_wval = acc_reg;
                    end else begin
                        ridx_next  = ridx_reg + 1'b1;
                        state_next = S_POP_SCAN;
                    end
                end else begin
                    fin      = 1'b1;
                    fin_wval = acc_reg;
                    fin_ea   = ea_reg;
                end
            end
            // walk the mask from R15 down, one slot per selected register
            S_PUSH_SCAN: begin
                if (cmd_reg.sel[ridx_reg]) begin
                    if (!in_range(push_slot, 3'd4)) begin
                        fin        = 1'b1;
                        fin_status = ST_FAULT;
                    end else begin
                        rf_we      = 1'b1;
                        rf_waddr   = SP_INDEX;
                        rf_wdata   = push_slot;
                        ea_next    = push_slot;
                        rf_raddr   = ridx_reg;
                        state_next = S_PUSH_RD;
                    end
                end else if (ridx_reg == 4'd0) begin
                    fin = 1'b1;
                end else begin
                    ridx_next = ridx_reg - 1'b1;
                end
            end
            S_PUSH_RD: begin
                src_next   = rf_q;
                cnt_next   = 2'd0;
                state_next = S_MEM_WR;
            end
            // walk the mask from R0 up
            S_POP_SCAN: begin
                cnt_next = 2'd0;
                acc_next = 32'd0;
                if (cmd_reg.sel[ridx_reg]) begin
                    if (!in_range(sp_reg, 3'd4)) begin
                        fin        = 1'b1;
                        fin_status = ST_FAULT;
                    end else begin
                        ea_next    = sp_reg;
                        state_next = S_MEM_RD;
                    end
                end else if (ridx_reg == PC_INDEX) begin
                    fin      = 1'b1;
                    fin_wval = wval_reg;
                end else begin
                    ridx_next = ridx_reg + 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (fin) begin
            state_next = S_IDLE;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            flag_n_reg    <= 1'b0;
            flag_z_reg    <= 1'b0;
            sp_reg        <= 32'd0;
            rf_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            flag_n_reg  <= flag_n_next;
            flag_z_reg  <= flag_z_next;
            if (rf_we) begin
                rf_valid_reg[rf_waddr] <= 1'b1;
                if (rf_waddr == SP_INDEX) begin
                    sp_reg <= rf_wdata;
                end
            end
            if (fin) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        rn_val_reg <= rn_val_next;
        idxv_reg   <= idxv_next;
        src_reg    <= src_next;
        ea_reg     <= ea_next;
        nb_reg     <= nb_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        ridx_reg   <= ridx_next;
        wval_reg   <= wval_next;
        if (fin) begin
            out_status_reg <= fin_status;
            out_wval_reg   <= fin_wval;
            out_ea_reg     <= fin_ea;
            out_n_reg      <= flag_n_next;
            out_z_reg      <= flag_z_next;
        end
    end

    // register file storage
    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[rf_waddr] <= rf_wdata;
        end
        rf_raw_reg     <= rf_mem[rf_raddr];
        rf_raddr_q_reg <= rf_raddr;
    end

    // data memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dmem[mem_addr] <= mem_wdata;
        end
        mem_q_reg <= dmem[mem_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_z_reg, out_n_reg, out_ea_reg, out_wval_reg, out_status_reg};

    `LSMU_ASSERT_NOW(a_pop_only_when_free, q_pop, !out_valid_reg)
    `LSMU_ASSERT_NOW(a_no_result_overwrite, fin, !out_valid_reg)
    `LSMU_ASSERT_NOW(a_error_has_no_value, fin && fin_status != ST_OK, fin_wval == 32'd0)
    `LSMU_ASSERT_NOW(a_write_only_on_store, mem_we && state_reg != S_CLEAR,
                     cmd_reg.kind == KIND_STORE || cmd_reg.kind == KIND_PUSH)
endmodule
`default_nettype wire

/* sv/arm_load_store_move_unit_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Data-transfer unit: executes one decoded MOV/MOVS, load, store, PUSH or POP
// per input transfer against a 16-word register file, N/Z flags and a byte
// memory of MEM_BYTES bytes.
// Input channel s_*: operation in s_tuser, remaining fields in s_tdata.
// Output channel m_*: one result per input (status, written value, address,
// N and Z flags) in m_tdata.
// A two-entry command queue sits between decode and execution, so the input
// side keeps taking transfers while the executor works or a result waits,
// until the queue is full. Loads and stores move one byte at a time through
// the single-port byte memory; PUSH and POP scan the mask one bit at a time.
// Throughput: one command at a time; the next leaves the queue in the cycle
// after the pending result is transferred.
// After reset the memory is cleared, one byte per cycle;
// items queue up meanwhile but are executed only after the pass.
// A stalled receiver holds the result register; the executor takes no new
// command until the pending result is transferred.
module arm_load_store_move_unit_core
    import arm_lsmu_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // operation[2:0]
    input  wire logic [2:0]   s_tuser,
    // access_width[1:0], addr_mode[4:2], src_is_literal[5], use_mask[6],
    // data_register_number[10:7], base_register_number[14:11],
    // index_register_number[18:15], displacement[50:19], literal_value[82:51],
    // register_mask[98:83], zero fill above
    input  wire logic [103:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status[1:0], written_value[33:2], effective_address[65:34],
    // flag_negative[66], flag_zero[67], zero fill above
    output logic [71:0]       m_tdata
);
    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_empty;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    arm_lsmu_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    arm_lsmu_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_cmd  (pop_cmd)
    );

    arm_lsmu_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_cmd    (pop_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );
endmodule
`default_nettype wire
